// ----- src/owdm_pkg.sv -----
// Shared types, constants and the Q1.15 sine table for the omni wheel drive mixer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package owdm_pkg;

  localparam int unsigned DUTY_LIMIT  = 65535;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NUM_WHEELS  = 4;

  // op codes as they arrive on the input
  localparam logic [2:0] OP_WHEELS_CORR   = 3'd0;
  localparam logic [2:0] OP_WHEELS_UNCORR = 3'd1;
  localparam logic [2:0] OP_MOVE_CORR     = 3'd2;
  localparam logic [2:0] OP_MOVE_UNCORR   = 3'd3;

  typedef enum logic [1:0] {
    KIND_WHEELS = 2'd0,
    KIND_MOVE   = 2'd1,
    KIND_BRAKE  = 2'd2
  } kind_e;

  // back end sequencer
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_COS  = 5'b00010,
    S_SIN  = 5'b00100,
    S_MIX  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  // classified command, front to back
  typedef struct packed {
    kind_e             kind;
    logic              corrected;
    logic [8:0]        angle_deg;   // 0..359
    logic [7:0]        speed;
    logic signed [7:0] corr;        // -100..100
    logic [3:0][8:0]   cmd;         // signed wheel commands, index 0 = left front
  } cmd_t;

  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } trig_t;

  localparam logic [15:0] SIN_Q15 [91] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  // sine of a whole degree in 0..359, folded onto the first quadrant
  function automatic trig_t sin_deg(input logic [8:0] deg);
    trig_t      r;
    logic [8:0] idx;
    begin
      if (deg <= 9'd90) begin
        idx   = deg;
        r.neg = 1'b0;
      end else if (deg <= 9'd180) begin
        idx   = 9'd180 - deg;
        r.neg = 1'b0;
      end else if (deg <= 9'd270) begin
        idx   = deg - 9'd180;
        r.neg = 1'b1;
      end else begin
        idx   = 9'd360 - deg;
        r.neg = 1'b1;
      end
      r.mag = SIN_Q15[idx[6:0]];
      return r;
    end
  endfunction

endpackage

// ----- src/owdm_front.sv -----
// Front end: decodes the op and reduces heading and angle for the back end.
// Depends on owdm_pkg.
`timescale 1ns / 1ps

module owdm_front import owdm_pkg::*; (
  input  logic [2:0]      op_i,
  input  logic [10:0]     angle_i,
  input  logic [7:0]      speed_i,
  input  logic [8:0]      heading_i,
  input  logic            look_back_i,
  input  logic [3:0][8:0] cmd_i,
  output cmd_t            cmd_o
);

  logic signed [10:0] c;
  logic signed [11:0] a;

  always_comb begin
    // heading correction: rear reference, single wrap, clamp to +-100
    c = $signed({{2{heading_i[8]}}, heading_i}) + (look_back_i ? 11'sd180 : 11'sd0);
    if (c > 11'sd180) begin
      c = c - 11'sd360;
    end else if (c < -11'sd180) begin
      c = c + 11'sd360;
    end
    if (c > 11'sd100) begin
      c = 11'sd100;
    end else if (c < -11'sd100) begin
      c = -11'sd100;
    end

    // travel angle: single wrap, then reduce into 0..359
    a = $signed({angle_i[10], angle_i});
    if (a > 12'sd360) begin
      a = a - 12'sd360;
    end else if (a < 12'sd0) begin
      a = a + 12'sd360;
    end
    if (a < 12'sd0) begin
      a = a + 12'sd360;
    end
    if (a < 12'sd0) begin
      a = a + 12'sd360;
    end
    if (a >= 12'sd360) begin
      a = a - 12'sd360;
    end

    cmd_o.angle_deg = a[8:0];
    cmd_o.corr      = c[7:0];
    cmd_o.speed     = speed_i;
    cmd_o.cmd       = cmd_i;

    case (op_i)
      OP_WHEELS_CORR: begin
        cmd_o.kind      = KIND_WHEELS;
        cmd_o.corrected = 1'b1;
      end
      OP_WHEELS_UNCORR: begin
        cmd_o.kind      = KIND_WHEELS;
        cmd_o.corrected = 1'b0;
      end
      OP_MOVE_CORR: begin
        cmd_o.kind      = KIND_MOVE;
        cmd_o.corrected = 1'b1;
      end
      OP_MOVE_UNCORR: begin
        cmd_o.kind      = KIND_MOVE;
        cmd_o.corrected = 1'b0;
      end
      default: begin
        cmd_o.kind      = KIND_BRAKE;
        cmd_o.corrected = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/owdm_queue.sv -----
// Small FIFO of classified commands between front and back end.
// Depends on owdm_pkg.
`timescale 1ns / 1ps

module owdm_queue import owdm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t            entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    begin
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
        return '0;
      end
      return p + QPTR_W'(1);
    end
  endfunction

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ----- src/owdm_back.sv -----
// Back end: trig products, wheel mixing, scaling and H-bridge pin/duty output.
// Holds the per-wheel held duty and the output register. Depends on owdm_pkg.
`timescale 1ns / 1ps

module owdm_back import owdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [71:0] out_data_o
);

  state_e             state_q, state_d;
  cmd_t               item_q;
  logic signed [9:0]  x_q, y_q;
  logic signed [10:0] wheel_q [NUM_WHEELS];
  logic signed [10:0] wheel_d [NUM_WHEELS];
  logic [15:0]        held_q  [NUM_WHEELS];
  logic [15:0]        held_d  [NUM_WHEELS];
  logic               out_valid_q;
  logic [71:0]        out_data_q;
  logic [71:0]        out_data_d;
  logic               load;

  // one shared multiplier for cosine then sine
  logic [9:0]         cos_sum;
  logic [8:0]         cos_deg;
  logic [8:0]         trig_arg;
  trig_t              trig;
  logic [23:0]        prod;
  logic signed [9:0]  trig_val;

  always_comb begin
    cos_sum  = {1'b0, item_q.angle_deg} + 10'd90;
    cos_deg  = (cos_sum >= 10'd360) ? 9'(cos_sum - 10'd360) : cos_sum[8:0];
    trig_arg = (state_q == S_COS) ? cos_deg : item_q.angle_deg;
    trig     = sin_deg(trig_arg);
    prod     = {8'd0, item_q.speed} * {8'd0, trig.mag};
    // magnitude first, so the shift truncates toward zero
    trig_val = trig.neg ? -$signed({1'b0, prod[23:15]}) : $signed({1'b0, prod[23:15]});
  end

  // mixing plus heading correction
  logic signed [10:0] xs, ys, corr_ext;
  always_comb begin
    xs       = {x_q[9], x_q};
    ys       = {y_q[9], y_q};
    corr_ext = item_q.corrected ? {{3{item_q.corr[7]}}, item_q.corr} : 11'sd0;
    if (item_q.kind == KIND_MOVE) begin
      wheel_d[0] = xs + ys + corr_ext;
      wheel_d[1] = xs - ys + corr_ext;
      wheel_d[2] = -xs - ys + corr_ext;
      wheel_d[3] = ys - xs + corr_ext;
    end else begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        wheel_d[i] = $signed({{2{item_q.cmd[i][8]}}, item_q.cmd[i]}) + corr_ext;
      end
    end
  end

  // scale by 255, saturate, pins and duty
  logic [10:0] wmag;
  logic [17:0] scaled;
  logic [15:0] duty;
  logic        pin_pos;
  logic        pin_a, pin_b;
  always_comb begin
    out_data_d = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      wmag    = wheel_q[i][10] ? 11'(-wheel_q[i]) : 11'(wheel_q[i]);
      scaled  = {wmag[9:0], 8'd0} - {8'd0, wmag[9:0]};
      duty    = (scaled > 18'(DUTY_LIMIT)) ? 16'(DUTY_LIMIT) : scaled[15:0];
      pin_pos = (i >= 2);  // level of pin A when driving forward
      held_d[i] = held_q[i];
      if (item_q.kind == KIND_BRAKE) begin
        pin_a = 1'b1;
        pin_b = 1'b1;
      end else if (!wheel_q[i][10] && (wheel_q[i] != 11'sd0)) begin
        pin_a     = pin_pos;
        pin_b     = !pin_pos;
        held_d[i] = duty;
      end else if (wheel_q[i][10] || !item_q.corrected) begin
        pin_a     = !pin_pos;
        pin_b     = pin_pos;
        held_d[i] = duty;
      end else begin
        // zero wheel in a corrected op brakes and keeps its duty
        pin_a = 1'b1;
        pin_b = 1'b1;
      end
      out_data_d[i*18 +: 18] = {held_d[i], pin_b, pin_a};
    end
  end

  assign load    = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_data_i.kind)
            KIND_MOVE:   state_d = S_COS;
            KIND_WHEELS: state_d = S_MIX;
            default:     state_d = S_EMIT;
          endcase
        end
      end
      S_COS:   state_d = S_SIN;
      S_SIN:   state_d = S_MIX;
      S_MIX:   state_d = S_EMIT;
      S_EMIT:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        held_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < NUM_WHEELS; i++) begin
          held_q[i] <= held_d[i];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_data_i;
    end
    if (state_q == S_COS) begin
      x_q <= trig_val;
    end
    if (state_q == S_SIN) begin
      y_q <= trig_val;
    end
    if (state_q == S_MIX) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        wheel_q[i] <= wheel_d[i];
      end
    end
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- src/omni_wheel_drive_mixer.sv -----
// Four-wheel omni drive mixer: top level, stream ports, front, queue and back end.
// Depends on owdm_pkg, owdm_front, owdm_queue and owdm_back.
// The back end sequencer takes one item at a time: cosine, sine, mix and emit
// for move commands, mix and emit for wheel commands, emit alone for brake, and
// it holds in emit while the result waits. Input transfers continue into a
// 2-entry queue while the back end works or the result waits. Reset clears held
// duties, the queue and the output valid; no clearing pass is needed.
`timescale 1ns / 1ps

module omni_wheel_drive_mixer import owdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata, from bit 0: angle[10:0], speed[18:11], heading[27:19], look_back[28],
  // left_front_cmd[37:29], left_rear_cmd[46:38], right_rear_cmd[55:47],
  // right_front_cmd[64:56], zero fill [71:65]
  input  logic [71:0] s_axis_tdata_i,
  // tuser: op[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata, from bit 0, per wheel in 18-bit slices (left_front, left_rear,
  // right_rear, right_front): pin_a, pin_b, duty[15:0]
  output logic [71:0] m_axis_tdata_o
);

  // field extraction
  logic [3:0][8:0] cmds;
  assign cmds[0] = s_axis_tdata_i[37:29];
  assign cmds[1] = s_axis_tdata_i[46:38];
  assign cmds[2] = s_axis_tdata_i[55:47];
  assign cmds[3] = s_axis_tdata_i[64:56];

  cmd_t front_cmd;
  cmd_t q_data;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;

  owdm_front u_front (
    .op_i        (s_axis_tuser_i),
    .angle_i     (s_axis_tdata_i[10:0]),
    .speed_i     (s_axis_tdata_i[18:11]),
    .heading_i   (s_axis_tdata_i[27:19]),
    .look_back_i (s_axis_tdata_i[28]),
    .cmd_i       (cmds),
    .cmd_o       (front_cmd)
  );

  // input transfer goes straight into the queue
  assign s_axis_tready_o = !q_full;
  assign push            = s_axis_tvalid_i && !q_full;

  owdm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // back end owns the held duties and the output register
  owdm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // the back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty command queue");

  // no bridge is ever left with both inputs low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[0] || m_axis_tdata_o[1]) &&
                         (m_axis_tdata_o[18] || m_axis_tdata_o[19]) &&
                         (m_axis_tdata_o[36] || m_axis_tdata_o[37]) &&
                         (m_axis_tdata_o[54] || m_axis_tdata_o[55])))
    else $error("bridge pins both low on a result");

  // a push into an empty queue shows up as valid on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop && !q_valid) |=> q_valid)
    else $error("pushed command not visible in queue");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for omni_wheel_drive_mixer: a queue-fed stream driver, a
// result monitor and an in-line predictor of the wheel pins and duties.
// Depends on owdm_pkg and the omni_wheel_drive_mixer RTL.
`timescale 1ns / 1ps

module testbench;
  import owdm_pkg::*;

  localparam int         CLK_HALF     = 10;
  localparam logic [2:0] OP_BRAKE     = 3'd4;   // 5..7 act as brake too
  localparam int         DUTY_MAX     = 65535;
  localparam int         RANDOM_ITEMS = 1000;
  localparam int         HOLD_OFF_AT  = 400;    // transfers in before the long stall
  localparam int         HOLD_OFF_LEN = 300;    // cycles of the long stall
  localparam int         DRAIN_AT     = 600;    // random item that waits for an empty pipe
  localparam int         TAIL_CYCLES  = 20;
  localparam int         MAX_REPORTS  = 10;

  // one command as the driver sees it; cmd[0] is the left front wheel
  typedef struct packed {
    logic            drain_first;  // hold this one back until all results are in
    logic [2:0]      op;
    logic [10:0]     angle;
    logic [7:0]      speed;
    logic [8:0]      heading;
    logic            look_back;
    logic [3:0][8:0] cmd;
  } mix_cmd_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [71:0] s_data  = '0;
  logic [2:0]  s_user  = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [71:0] m_data;

  mix_cmd_t    cmd_pending[$];
  logic [71:0] wheel_out_expected[$];
  logic [15:0] duty_hold [4] = '{16'd0, 16'd0, 16'd0, 16'd0};
  string       wheel_name [4] = '{"left_front", "left_rear", "right_rear", "right_front"};

  logic        in_fire     = 1'b0;
  int          n_accepted  = 0;
  int          n_mismatch  = 0;
  int          burst_left  = 8;
  int          gap_left    = 0;
  int          hold_left   = 0;
  logic        hold_done   = 1'b0;
  logic [11:0] rx_cycle    = '0;

  omni_wheel_drive_mixer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Q1.15 sine of a whole degree 0..359, folded onto the first quadrant
  function automatic int sine_q15(input int deg);
    if (deg <= 90)  return int'(SIN_Q15[deg]);
    if (deg <= 180) return int'(SIN_Q15[180 - deg]);
    if (deg <= 270) return -int'(SIN_Q15[deg - 180]);
    return -int'(SIN_Q15[360 - deg]);
  endfunction

  // speed times a Q1.15 factor, truncated toward zero
  function automatic int scale_q15(input int spd, input int q);
    int p;
    p = spd * q;
    if (p >= 0) return p >>> 15;
    return -((-p) >>> 15);
  endfunction

  // Expected output word for one command; updates the held duties.
  function automatic logic [71:0] predict_wheel_drive(input mix_cmd_t c);
    logic [71:0] r;
    int          wv [4];
    int          a, d, spd, x, y, corr, w;
    logic        corrected, a_pos;
    r = '0;
    if (c.op >= OP_BRAKE) begin
      for (int i = 0; i < 4; i++) r[18*i +: 18] = {duty_hold[i], 2'b11};
      return r;
    end
    corrected = (c.op == OP_WHEELS_CORR) || (c.op == OP_MOVE_CORR);
    if (c.op == OP_WHEELS_CORR || c.op == OP_WHEELS_UNCORR) begin
      for (int i = 0; i < 4; i++) wv[i] = int'($signed(c.cmd[i]));
    end else begin
      a   = int'($signed(c.angle));
      spd = int'(c.speed);
      // single wrap, then a true modulo for the table lookup
      if (a > 360) a -= 360;
      if (a < 0) a += 360;
      d = a % 360;
      if (d < 0) d += 360;
      x = scale_q15(spd, sine_q15((d + 90) % 360));
      y = scale_q15(spd, sine_q15(d));
      wv[0] = x + y;
      wv[1] = x - y;
      wv[2] = -x - y;
      wv[3] = y - x;
    end
    if (corrected) begin
      corr = int'($signed(c.heading)) + (c.look_back ? 180 : 0);
      if (corr > 180) corr -= 360;
      if (corr < -180) corr += 360;
      if (corr > 100) corr = 100;
      if (corr < -100) corr = -100;
      for (int i = 0; i < 4; i++) wv[i] += corr;
    end
    for (int i = 0; i < 4; i++) begin
      w = wv[i] * 255;
      if (w > DUTY_MAX) w = DUTY_MAX;
      if (w < -DUTY_MAX) w = -DUTY_MAX;
      a_pos = (i >= 2);  // right wheels run forward with pin A high
      if (w > 0) begin
        r[18*i]     = a_pos;
        r[18*i + 1] = ~a_pos;
        duty_hold[i] = 16'(w);
      end else if (w < 0 || !corrected) begin
        // uncorrected zero falls in here with duty 0
        r[18*i]     = ~a_pos;
        r[18*i + 1] = a_pos;
        duty_hold[i] = 16'(-w);
      end else begin
        // corrected zero: brake, held duty stays
        r[18*i]     = 1'b1;
        r[18*i + 1] = 1'b1;
      end
      r[18*i + 2 +: 16] = duty_hold[i];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string wheel, input string field,
                             input logic [15:0] exp_v, input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      if (n_mismatch < MAX_REPORTS)
        $display("mismatch on %s %s: expected %0d, got %0d", wheel, field, exp_v, got_v);
      n_mismatch++;
    end
  endtask

  task automatic check_wheels(input logic [71:0] exp_w, input logic [71:0] got_w);
    for (int i = 0; i < 4; i++) begin
      check_field(wheel_name[i], "pin_a", 16'(exp_w[18*i]), 16'(got_w[18*i]));
      check_field(wheel_name[i], "pin_b", 16'(exp_w[18*i + 1]), 16'(got_w[18*i + 1]));
      check_field(wheel_name[i], "duty", exp_w[18*i + 2 +: 16], got_w[18*i + 2 +: 16]);
    end
  endtask

  // input transfers feed the predictor, output transfers are checked in order
  always @(posedge clk_i) begin
    in_fire <= s_valid && s_ready;
    if (rst_ni && s_valid && s_ready) begin
      wheel_out_expected.push_back(predict_wheel_drive(cmd_pending.pop_front()));
      n_accepted <= n_accepted + 1;
    end
    if (rst_ni && m_valid && m_ready) begin
      if (wheel_out_expected.size() == 0) begin
        if (n_mismatch < MAX_REPORTS)
          $display("result with nothing pending: %h", m_data);
        n_mismatch++;
      end else begin
        check_wheels(wheel_out_expected.pop_front(), m_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts with random gaps, changes at the falling edge
  // ---------------------------------------------------------------------------

  function automatic int next_gap();
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(1, 3));
      1:       return int'($urandom_range(4, 12));
      default: return 0;
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (s_valid && !in_fire) begin
      // offer still open, hold it
    end else if (gap_left != 0) begin
      s_valid  <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (cmd_pending.size() == 0 ||
                 (cmd_pending[0].drain_first && wheel_out_expected.size() != 0)) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= 1'b1;
      s_data  <= {7'd0, cmd_pending[0].cmd, cmd_pending[0].look_back,
                  cmd_pending[0].heading, cmd_pending[0].speed, cmd_pending[0].angle};
      s_user  <= cmd_pending[0].op;
      if (burst_left <= 1) begin
        burst_left <= int'($urandom_range(1, 20));
        gap_left   <= next_gap();
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern follows bits 8:6 of a free-running counter, plus one long hold-off
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_OFF_AT) begin
      hold_left <= HOLD_OFF_LEN;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 12'd1;
    if (hold_left != 0) begin
      m_ready <= 1'b0;
    end else begin
      case (rx_cycle[8:6])
        3'd0, 3'd1: m_ready <= 1'b1;
        3'd2:       m_ready <= ($urandom_range(0, 1) == 0);
        3'd3:       m_ready <= ($urandom_range(0, 9) < 2);
        3'd4:       m_ready <= (rx_cycle[1:0] == 2'd0);
        3'd5:       m_ready <= rx_cycle[2];
        default:    m_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic mix_cmd_t wheels_item(input logic [2:0] op, input int lf, input int lr,
                                           input int rr, input int rf, input int hdg,
                                           input logic lb);
    mix_cmd_t c;
    c = '0;
    c.op        = op;
    c.cmd[0]    = 9'(lf);
    c.cmd[1]    = 9'(lr);
    c.cmd[2]    = 9'(rr);
    c.cmd[3]    = 9'(rf);
    c.heading   = 9'(hdg);
    c.look_back = lb;
    return c;
  endfunction

  function automatic mix_cmd_t move_item(input logic [2:0] op, input int ang, input int spd,
                                         input int hdg, input logic lb);
    mix_cmd_t c;
    c = '0;
    c.op        = op;
    c.angle     = 11'(ang);
    c.speed     = 8'(spd);
    c.heading   = 9'(hdg);
    c.look_back = lb;
    return c;
  endfunction

  function automatic int pick_cmd();
    case ($urandom_range(0, 7))
      0:       return int'($urandom_range(0, 6)) - 3;
      1:       return ($urandom_range(0, 1) == 0) ? 255 : -255;
      default: return int'($urandom_range(0, 510)) - 255;
    endcase
  endfunction

  function automatic int pick_heading();
    case ($urandom_range(0, 5))
      0:       return int'($urandom_range(0, 6)) - 3;
      1:       return ($urandom_range(0, 1) == 0) ? 180 : -180;
      2:       return int'($urandom_range(95, 105)) * (($urandom_range(0, 1) == 0) ? 1 : -1);
      default: return int'($urandom_range(0, 360)) - 180;
    endcase
  endfunction

  function automatic mix_cmd_t random_item();
    mix_cmd_t c;
    int       k, h, j;
    k = int'($urandom_range(0, 99));
    // start from noise over every bit of the command fields, with op among the four mix ops
    c.drain_first = 1'b0;
    c.op          = 3'($urandom_range(0, 3));
    c.angle       = 11'($urandom);
    c.speed       = 8'($urandom);
    c.heading     = 9'($urandom);
    c.look_back   = 1'($urandom);
    for (int i = 0; i < 4; i++) c.cmd[i] = 9'($urandom);
    if (k < 12) begin
      c.op = 3'($urandom_range(4, 7));
    end else if (k >= 22) begin
      c.angle = 11'(int'($urandom_range(0, 1080)) - 360);
      case ($urandom_range(0, 7))
        0:       c.speed = 8'd0;
        1:       c.speed = 8'($urandom_range(0, 255));
        default: c.speed = 8'($urandom_range(0, 200));
      endcase
      c.heading   = 9'(pick_heading());
      c.look_back = 1'($urandom_range(0, 1));
      for (int i = 0; i < 4; i++) c.cmd[i] = 9'(pick_cmd());
      // make one wheel cancel the correction so that it brakes
      if (c.op == OP_WHEELS_CORR && $urandom_range(0, 3) == 0) begin
        h           = int'($urandom_range(0, 40)) - 20;
        j           = int'($urandom_range(0, 3));
        c.heading   = 9'(h);
        c.look_back = 1'b0;
        c.cmd[j]    = 9'(-h);
      end
    end
    return c;
  endfunction

  initial begin
    mix_cmd_t c;

    // directed part
    cmd_pending.push_back(wheels_item(OP_BRAKE, 0, 0, 0, 0, 0, 1'b0));
    cmd_pending.push_back(wheels_item(OP_WHEELS_UNCORR, 255, -255, 0, 1, 0, 1'b0));
    cmd_pending.push_back(wheels_item(OP_WHEELS_CORR, 255, -255, 100, -1, 0, 1'b0));
    // all zero in a corrected op with zero heading: brake pins, held duties stay
    cmd_pending.push_back(wheels_item(OP_WHEELS_CORR, 0, 0, 0, 0, 0, 1'b0));
    cmd_pending.push_back(wheels_item(OP_BRAKE, 3, 3, 3, 3, 3, 1'b1));
    cmd_pending.push_back(wheels_item(3'd5, -1, 1, -1, 1, -1, 1'b1));
    cmd_pending.push_back(wheels_item(3'd6, 255, 255, 255, 255, 255, 1'b0));
    cmd_pending.push_back(wheels_item(3'd7, -256, -256, -256, -256, -256, 1'b1));
    // clamp to +100 and to -100, and saturation past the duty limit
    cmd_pending.push_back(wheels_item(OP_WHEELS_CORR, 255, 255, -255, -255, 180, 1'b0));
    cmd_pending.push_back(wheels_item(OP_WHEELS_CORR, 255, -255, 255, -255, -180, 1'b0));
    // rear reference wraps: -180+180 -> 0, 180+180 -> 0, 100+180 -> -80
    cmd_pending.push_back(wheels_item(OP_WHEELS_CORR, 10, -10, 20, -20, -180, 1'b1));
    cmd_pending.push_back(wheels_item(OP_WHEELS_CORR, 0, 5, -5, 0, 180, 1'b1));
    cmd_pending.push_back(wheels_item(OP_WHEELS_CORR, 80, -80, 0, 1, 100, 1'b1));
    // headings outside the stated range
    cmd_pending.push_back(wheels_item(OP_WHEELS_CORR, -256, 255, 0, -100, -256, 1'b0));
    cmd_pending.push_back(wheels_item(OP_WHEELS_CORR, -256, 255, -75, 0, 255, 1'b1));
    cmd_pending.push_back(wheels_item(OP_WHEELS_UNCORR, 0, 0, 0, 0, 50, 1'b1));
    // moves across the quadrants and both single wraps
    cmd_pending.push_back(move_item(OP_MOVE_UNCORR, 0, 200, 0, 1'b0));
    cmd_pending.push_back(move_item(OP_MOVE_UNCORR, 90, 200, 0, 1'b0));
    cmd_pending.push_back(move_item(OP_MOVE_UNCORR, 180, 255, 0, 1'b0));
    cmd_pending.push_back(move_item(OP_MOVE_UNCORR, 270, 200, 0, 1'b0));
    cmd_pending.push_back(move_item(OP_MOVE_UNCORR, -360, 200, 0, 1'b0));
    cmd_pending.push_back(move_item(OP_MOVE_UNCORR, 720, 200, 0, 1'b0));
    cmd_pending.push_back(move_item(OP_MOVE_UNCORR, -1024, 255, 0, 1'b0));
    cmd_pending.push_back(move_item(OP_MOVE_UNCORR, 1023, 255, 0, 1'b0));
    cmd_pending.push_back(move_item(OP_MOVE_CORR, 45, 200, 30, 1'b0));
    cmd_pending.push_back(move_item(OP_MOVE_CORR, 0, 0, 0, 1'b0));
    cmd_pending.push_back(move_item(OP_MOVE_CORR, 135, 200, -180, 1'b1));

    // random part
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      c = random_item();
      if (n == 0 || n == DRAIN_AT) c.drain_first = 1'b1;
      cmd_pending.push_back(c);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_pending.size() != 0 || wheel_out_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/owdm_pkg.sv
src/owdm_front.sv
src/owdm_queue.sv
src/owdm_back.sv
src/omni_wheel_drive_mixer.sv
tb/testbench.sv
